### rtl/tfc_pkg.sv
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared types and constants of the thermal fan controller: register
// indexes, reset values, duty classification codes and the control word that
// travels from the front end to the duty back end.
// ----------------------------------------------------------------------------
package tfc_pkg;

   // Width of the hysteresis register, fixed by the register map.
   localparam int HYST_BITS = 8;

   // Width of the configuration register index.
   localparam int CSR_INDEX_BITS = 3;

   // Reset values of the configuration registers, tenths of a degree.
   localparam int HEAT_START_RESET        = 400;
   localparam int HEAT_FULL_RESET         = 700;
   localparam int HEAT_HYSTERESIS_RESET   = 20;
   localparam int CHANNEL_ON_LEVEL_RESET  = 700;
   localparam int CHANNEL_OFF_LEVEL_RESET = 500;
   localparam int ALARM_LEVEL_RESET       = 800;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_HEAT_START        = 3'd0,
      REG_HEAT_FULL         = 3'd1,
      REG_HEAT_HYSTERESIS   = 3'd2,
      REG_CHANNEL_ON_LEVEL  = 3'd3,
      REG_CHANNEL_OFF_LEVEL = 3'd4,
      REG_ALARM_LEVEL       = 3'd5
   } csr_index_type;

   // How the back end forms the cooling fan duty of one reading.
   typedef enum logic [1:0] {
      KIND_ZERO   = 2'd0,
      KIND_FULL   = 2'd1,
      KIND_DIVIDE = 2'd2
   } kind_type;

   // Control word of one queued reading.
   typedef struct packed {
      kind_type kind;
      logic     channel_fan;
      logic     overheat;
   } ctrl_type;

endpackage

### rtl/tfc_queue.sv
// ----------------------------------------------------------------------------
// tfc_queue
// Small first-in first-out queue between the front end and the duty back
// end. The head entry is presented combinationally while the queue is not
// empty.
// ----------------------------------------------------------------------------
module tfc_queue #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] head_data
);

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]      entry_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   assign full      = (count_ff == COUNT_BITS'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/tfc_front.sv
// ----------------------------------------------------------------------------
// tfc_front
// Front end: holds the configuration registers and both hysteresis flags,
// accepts one reading per transfer, forms the hottest values, updates the
// flags and classifies the cooling fan duty for the back end.
// ----------------------------------------------------------------------------
module tfc_front #(
   parameter int TEMP_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [tfc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [TEMP_BITS-1:0]                csr_wdata,
   input  logic                                accept,
   input  logic signed [TEMP_BITS-1:0]         board_temp,
   input  logic signed [TEMP_BITS-1:0]         high_side_temp,
   input  logic signed [TEMP_BITS-1:0]         low_side_temp,
   input  logic signed [TEMP_BITS-1:0]         driver_temp,
   output tfc_pkg::ctrl_type                   ctrl,
   output logic [TEMP_BITS-1:0]                numerator,
   output logic [TEMP_BITS-1:0]                denominator,
   output logic signed [TEMP_BITS-1:0]         hottest_temp
);

   // Two guard bits hold start plus or minus the hysteresis without overflow.
   localparam int CW = TEMP_BITS + 2;

   logic signed [TEMP_BITS-1:0]        heat_start_ff;
   logic signed [TEMP_BITS-1:0]        heat_full_ff;
   logic [tfc_pkg::HYST_BITS-1:0]      heat_hysteresis_ff;
   logic signed [TEMP_BITS-1:0]        channel_on_level_ff;
   logic signed [TEMP_BITS-1:0]        channel_off_level_ff;
   logic signed [TEMP_BITS-1:0]        alarm_level_ff;
   logic                               heat_fan_enabled_ff, heat_fan_enabled_in;
   logic                               channel_fan_enabled_ff, channel_fan_enabled_in;

   logic signed [TEMP_BITS-1:0] stage_max;
   logic signed [TEMP_BITS-1:0] board_high_max;
   logic signed [CW-1:0]        stage_ext;
   logic signed [CW-1:0]        start_ext;
   logic signed [CW-1:0]        full_ext;
   logic signed [CW-1:0]        hyst_ext;
   logic signed [CW-1:0]        upper_level;
   logic signed [CW-1:0]        lower_level;
   logic signed [CW-1:0]        num_wide;
   logic signed [CW-1:0]        den_wide;

   // Hottest of the board and power stage, then of all four readings.
   always_comb begin
      board_high_max = (board_temp > high_side_temp) ? board_temp : high_side_temp;
      stage_max      = (board_high_max > low_side_temp) ? board_high_max : low_side_temp;
      hottest_temp   = (stage_max > driver_temp) ? stage_max : driver_temp;
   end

   // Hysteresis band and curve distances at extended width.
   always_comb begin
      stage_ext   = CW'(stage_max);
      start_ext   = CW'(heat_start_ff);
      full_ext    = CW'(heat_full_ff);
      hyst_ext    = $signed(CW'(heat_hysteresis_ff));
      upper_level = start_ext + hyst_ext;
      lower_level = start_ext - hyst_ext;
      num_wide    = stage_ext - start_ext;
      den_wide    = full_ext - start_ext;
   end

   // Flag updates for the current reading.
   always_comb begin
      heat_fan_enabled_in = heat_fan_enabled_ff;
      if (stage_ext > upper_level) begin
         heat_fan_enabled_in = 1'b1;
      end else if (stage_ext < lower_level) begin
         heat_fan_enabled_in = 1'b0;
      end
      channel_fan_enabled_in = channel_fan_enabled_ff;
      if (hottest_temp >= channel_on_level_ff) begin
         channel_fan_enabled_in = 1'b1;
      end else if (hottest_temp <= channel_off_level_ff) begin
         channel_fan_enabled_in = 1'b0;
      end
   end

   // Duty classification. The divide case only arises strictly between the
   // start and full points, so both distances are positive and fit.
   always_comb begin
      ctrl.channel_fan = channel_fan_enabled_in;
      ctrl.overheat    = (hottest_temp >= alarm_level_ff);
      if (!heat_fan_enabled_in) begin
         ctrl.kind = tfc_pkg::KIND_ZERO;
      end else if (stage_max >= heat_full_ff) begin
         ctrl.kind = tfc_pkg::KIND_FULL;
      end else if (stage_max <= heat_start_ff) begin
         ctrl.kind = tfc_pkg::KIND_ZERO;
      end else begin
         ctrl.kind = tfc_pkg::KIND_DIVIDE;
      end
      numerator   = num_wide[TEMP_BITS-1:0];
      denominator = den_wide[TEMP_BITS-1:0];
   end

   // Configuration registers and hysteresis flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         heat_start_ff          <= TEMP_BITS'(tfc_pkg::HEAT_START_RESET);
         heat_full_ff           <= TEMP_BITS'(tfc_pkg::HEAT_FULL_RESET);
         heat_hysteresis_ff     <= tfc_pkg::HYST_BITS'(tfc_pkg::HEAT_HYSTERESIS_RESET);
         channel_on_level_ff    <= TEMP_BITS'(tfc_pkg::CHANNEL_ON_LEVEL_RESET);
         channel_off_level_ff   <= TEMP_BITS'(tfc_pkg::CHANNEL_OFF_LEVEL_RESET);
         alarm_level_ff         <= TEMP_BITS'(tfc_pkg::ALARM_LEVEL_RESET);
         heat_fan_enabled_ff    <= 1'b0;
         channel_fan_enabled_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               tfc_pkg::REG_HEAT_START: begin
                  heat_start_ff <= csr_wdata;
               end
               tfc_pkg::REG_HEAT_FULL: begin
                  heat_full_ff <= csr_wdata;
               end
               tfc_pkg::REG_HEAT_HYSTERESIS: begin
                  heat_hysteresis_ff <= csr_wdata[tfc_pkg::HYST_BITS-1:0];
               end
               tfc_pkg::REG_CHANNEL_ON_LEVEL: begin
                  channel_on_level_ff <= csr_wdata;
               end
               tfc_pkg::REG_CHANNEL_OFF_LEVEL: begin
                  channel_off_level_ff <= csr_wdata;
               end
               tfc_pkg::REG_ALARM_LEVEL: begin
                  alarm_level_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (accept) begin
            heat_fan_enabled_ff    <= heat_fan_enabled_in;
            channel_fan_enabled_ff <= channel_fan_enabled_in;
         end
      end
   end

endmodule

### rtl/tfc_back.sv
// ----------------------------------------------------------------------------
// tfc_back
// Back end: takes classified readings from the queue, works out the duty of
// the linear curve with a restoring divider, one quotient bit per cycle, and
// holds the result in the output register until it is transferred.
// ----------------------------------------------------------------------------
module tfc_back #(
   parameter int DUTY_BITS = 8,
   parameter int TEMP_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         entry_valid,
   input  tfc_pkg::ctrl_type            entry_ctrl,
   input  logic [TEMP_BITS-1:0]         entry_numerator,
   input  logic [TEMP_BITS-1:0]         entry_denominator,
   input  logic signed [TEMP_BITS-1:0]  entry_hottest,
   output logic                         entry_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [DUTY_BITS-1:0]         heat_duty,
   output logic                         channel_fan,
   output logic                         overheat,
   output logic signed [TEMP_BITS-1:0]  hottest_temp
);

   localparam int DIVIDEND_BITS = TEMP_BITS + DUTY_BITS;
   localparam int STEP_BITS     = $clog2(DUTY_BITS + 1);

   typedef enum logic {
      ST_IDLE,
      ST_DIVIDE
   } state_type;

   state_type                   state_ff, state_in;
   logic [STEP_BITS-1:0]        step_ff, step_in;
   logic [TEMP_BITS-1:0]        rem_ff, rem_in;
   logic [DUTY_BITS-1:0]        quo_ff, quo_in;
   logic [TEMP_BITS-1:0]        den_ff, den_in;
   logic                        channel_fan_ff, channel_fan_in;
   logic                        overheat_ff, overheat_in;
   logic signed [TEMP_BITS-1:0] hottest_ff, hottest_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [DUTY_BITS-1:0]        duty_out_ff, duty_out_in;
   logic                        fan_out_ff, fan_out_in;
   logic                        overheat_out_ff, overheat_out_in;
   logic signed [TEMP_BITS-1:0] hottest_out_ff, hottest_out_in;

   logic                        rsp_free;
   logic [DIVIDEND_BITS-1:0]    dividend;
   logic [TEMP_BITS:0]          trial;
   logic                        fits;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Dividend is the distance times full duty: a shift and a subtract.
   assign dividend = {entry_numerator, {DUTY_BITS{1'b0}}}
                   - DIVIDEND_BITS'(entry_numerator);

   // One restoring step: bring down the next dividend bit and try the divisor.
   always_comb begin
      trial = {rem_ff, quo_ff[DUTY_BITS-1]};
      fits  = (trial >= {1'b0, den_ff});
   end

   always_comb begin
      state_in        = state_ff;
      step_in         = step_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;
      den_in          = den_ff;
      channel_fan_in  = channel_fan_ff;
      overheat_in     = overheat_ff;
      hottest_in      = hottest_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      duty_out_in     = duty_out_ff;
      fan_out_in      = fan_out_ff;
      overheat_out_in = overheat_out_ff;
      hottest_out_in  = hottest_out_ff;
      entry_pop       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (entry_valid) begin
               if (entry_ctrl.kind == tfc_pkg::KIND_DIVIDE) begin
                  // Load the divider; the upper dividend part is below the divisor.
                  entry_pop      = 1'b1;
                  rem_in         = dividend[DIVIDEND_BITS-1:DUTY_BITS];
                  quo_in         = dividend[DUTY_BITS-1:0];
                  den_in         = entry_denominator;
                  step_in        = STEP_BITS'(DUTY_BITS);
                  channel_fan_in = entry_ctrl.channel_fan;
                  overheat_in    = entry_ctrl.overheat;
                  hottest_in     = entry_hottest;
                  state_in       = ST_DIVIDE;
               end else if (rsp_free) begin
                  // Zero or full duty goes straight to the output register.
                  entry_pop       = 1'b1;
                  rsp_valid_in    = 1'b1;
                  duty_out_in     = (entry_ctrl.kind == tfc_pkg::KIND_FULL)
                                  ? {DUTY_BITS{1'b1}} : '0;
                  fan_out_in      = entry_ctrl.channel_fan;
                  overheat_out_in = entry_ctrl.overheat;
                  hottest_out_in  = entry_hottest;
               end
            end
         end
         ST_DIVIDE: begin
            if (step_ff != '0) begin
               rem_in  = fits ? TEMP_BITS'(trial - {1'b0, den_ff}) : trial[TEMP_BITS-1:0];
               quo_in  = {quo_ff[DUTY_BITS-2:0], fits};
               step_in = step_ff - 1'b1;
            end else if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               duty_out_in     = quo_ff;
               fan_out_in      = channel_fan_ff;
               overheat_out_in = overheat_ff;
               hottest_out_in  = hottest_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff         <= step_in;
      rem_ff          <= rem_in;
      quo_ff          <= quo_in;
      den_ff          <= den_in;
      channel_fan_ff  <= channel_fan_in;
      overheat_ff     <= overheat_in;
      hottest_ff      <= hottest_in;
      duty_out_ff     <= duty_out_in;
      fan_out_ff      <= fan_out_in;
      overheat_out_ff <= overheat_out_in;
      hottest_out_ff  <= hottest_out_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign heat_duty    = duty_out_ff;
   assign channel_fan  = fan_out_ff;
   assign overheat     = overheat_out_ff;
   assign hottest_temp = hottest_out_ff;

endmodule

### rtl/thermal_fan_controller.sv
// ----------------------------------------------------------------------------
// thermal_fan_controller
// Two-fan thermal controller: cooling fan duty curve with hysteresis, an
// on/off channel fan with hysteresis and an overheat alarm.
// ----------------------------------------------------------------------------
// Each request transfer carries four temperatures in signed tenths of a
// degree and yields exactly one response transfer, in order. The front end
// takes a reading and updates both hysteresis flags at once; a two-entry
// queue follows, so readings keep being taken while the back end works. A
// reading between the start and full points goes to the restoring divider,
// which yields one duty bit per cycle; zero and full duty go straight to the
// output register. The back end ends one reading before it takes the next.
// The user must write configuration through csr_wr_en, csr_index and
// csr_wdata only while no reading is in flight; the block does not enforce
// it. Indexes beyond the register list are ignored.
module thermal_fan_controller #(
   parameter int DUTY_BITS = 8,
   parameter int TEMP_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request fields from bit 0: board_temp, high_side_temp, low_side_temp,
   // driver_temp, each TEMP_BITS wide.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((4*TEMP_BITS+7)/8)*8-1:0]    req_tdata,
   // Response fields from bit 0: heat_duty, channel_fan, overheat,
   // hottest_temp.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((DUTY_BITS+TEMP_BITS+9)/8)*8-1:0] rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [tfc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [TEMP_BITS-1:0]                csr_wdata
);

   localparam int CTRL_BITS  = $bits(tfc_pkg::ctrl_type);
   localparam int ENTRY_BITS = CTRL_BITS + 3 * TEMP_BITS;
   localparam int QUEUE_DEPTH = 2;

   logic                        accept;
   logic                        queue_full;
   logic                        queue_not_empty;
   logic                        queue_pop;
   logic [ENTRY_BITS-1:0]       push_entry;
   logic [ENTRY_BITS-1:0]       head_entry;

   tfc_pkg::ctrl_type           front_ctrl;
   logic [TEMP_BITS-1:0]        front_numerator;
   logic [TEMP_BITS-1:0]        front_denominator;
   logic signed [TEMP_BITS-1:0] front_hottest;

   tfc_pkg::ctrl_type           head_ctrl;
   logic [TEMP_BITS-1:0]        head_numerator;
   logic [TEMP_BITS-1:0]        head_denominator;
   logic signed [TEMP_BITS-1:0] head_hottest;

   logic [DUTY_BITS-1:0]        heat_duty;
   logic                        channel_fan;
   logic                        overheat;
   logic signed [TEMP_BITS-1:0] hottest_temp;

   // A request transfer can happen whenever the queue has room.
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   tfc_front #(
      .TEMP_BITS (TEMP_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .accept         (accept),
      .board_temp     ($signed(req_tdata[TEMP_BITS-1:0])),
      .high_side_temp ($signed(req_tdata[2*TEMP_BITS-1:TEMP_BITS])),
      .low_side_temp  ($signed(req_tdata[3*TEMP_BITS-1:2*TEMP_BITS])),
      .driver_temp    ($signed(req_tdata[4*TEMP_BITS-1:3*TEMP_BITS])),
      .ctrl           (front_ctrl),
      .numerator      (front_numerator),
      .denominator    (front_denominator),
      .hottest_temp   (front_hottest)
   );

   // Queue entry layout from bit 0: control, numerator, denominator, hottest.
   assign push_entry = {front_hottest, front_denominator, front_numerator, front_ctrl};

   tfc_queue #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (push_entry),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .head_data (head_entry)
   );

   assign head_ctrl        = tfc_pkg::ctrl_type'(head_entry[CTRL_BITS-1:0]);
   assign head_numerator   = head_entry[CTRL_BITS+TEMP_BITS-1:CTRL_BITS];
   assign head_denominator = head_entry[CTRL_BITS+2*TEMP_BITS-1:CTRL_BITS+TEMP_BITS];
   assign head_hottest     = $signed(head_entry[ENTRY_BITS-1:CTRL_BITS+2*TEMP_BITS]);

   tfc_back #(
      .DUTY_BITS (DUTY_BITS),
      .TEMP_BITS (TEMP_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .entry_valid       (queue_not_empty),
      .entry_ctrl        (head_ctrl),
      .entry_numerator   (head_numerator),
      .entry_denominator (head_denominator),
      .entry_hottest     (head_hottest),
      .entry_pop         (queue_pop),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .heat_duty         (heat_duty),
      .channel_fan       (channel_fan),
      .overheat          (overheat),
      .hottest_temp      (hottest_temp)
   );

   // Pack the response fields, zero filled to whole bytes.
   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[DUTY_BITS-1:0]                     = heat_duty;
      rsp_tdata[DUTY_BITS]                         = channel_fan;
      rsp_tdata[DUTY_BITS+1]                       = overheat;
      rsp_tdata[DUTY_BITS+TEMP_BITS+1:DUTY_BITS+2] = hottest_temp;
   end

endmodule
